// ===== rtl/mfb_pkg.sv =====
// Shared types, constants and helpers for the mono framebuffer blitter.
`timescale 1ns / 1ps

package mfb_pkg;

    localparam int PANEL_WIDTH     = 128;
    localparam int PANEL_HEIGHT    = 64;
    localparam int PIXELS_PER_BYTE = 8;

    // Storage geometry follows the command field widths.
    localparam int X_W       = 7;
    localparam int Y_W       = 6;
    localparam int COL_SPACE = 1 << X_W;
    localparam int ROW_DEPTH = 1 << Y_W;
    localparam int SRC_W     = 64;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int COL_W     = X_W + 1;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 16;

    // Columns that exist on the panel; column 0 is the MSB.
    localparam logic [COL_SPACE-1:0] PANEL_MASK = ~({COL_SPACE{1'b1}} >> PANEL_WIDTH);

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_CLR  = 2'd1,
        MODE_BLIT = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [SRC_W-1:0]   row_bits;
        logic [LEN_W-1:0]   row_len;
        logic [X_W-1:0]     clip_x;
        logic [Y_W-1:0]     clip_y;
    } t_cmd;

    typedef struct packed {
        logic                 en;
        logic [Y_W-1:0]       addr;
        logic [COL_SPACE-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              clipped;
    } t_result;

    // Row touched by a command; pixel ops clamp the row to the panel.
    function automatic logic [Y_W-1:0] f_row_addr(input t_mode mode, input logic [Y_W-1:0] y);
        logic [Y_W-1:0] addr;
        addr = y;
        if ((mode == MODE_SET || mode == MODE_CLR) &&
            ({1'b0, y} >= (Y_W+1)'(PANEL_HEIGHT))) begin
            addr = Y_W'(PANEL_HEIGHT - 1);
        end
        return addr;
    endfunction

endpackage

// ===== rtl/mfb_frame_mem.sv =====
// Framebuffer row memory with per-row valid bits and registered read.
`timescale 1ns / 1ps

module mfb_frame_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [mfb_pkg::Y_W-1:0]       i_rd_addr,
    output logic [mfb_pkg::COL_SPACE-1:0] o_rd_data,
    input  mfb_pkg::t_mem_wr              i_wr
);
    import mfb_pkg::*;

    logic [COL_SPACE-1:0] r_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] r_valid;
    logic [COL_SPACE-1:0] r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // rows never written since reset read as blank
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/mfb_cmd_unit.sv =====
// Row read-modify-write: pixel set/clear, clipped blit and byte read.
`timescale 1ns / 1ps

module mfb_cmd_unit (
    input  mfb_pkg::t_cmd                 i_cmd,
    input  logic [mfb_pkg::COL_SPACE-1:0] i_old_row,
    output mfb_pkg::t_mem_wr              o_wr,
    output mfb_pkg::t_result              o_res
);
    import mfb_pkg::*;

    logic [X_W-1:0]       px;
    logic                 px_clip;
    logic                 py_clip;
    logic [COL_SPACE-1:0] pix_mask;
    logic [LEN_W-1:0]     n_sat;
    logic [LEN_W-1:0]     n_len;
    logic [X_W-1:0]       diff;
    logic                 cx_lt;
    logic                 len_clip;
    logic                 row_skip;
    logic [COL_SPACE-1:0] span;
    logic [COL_SPACE-1:0] src;
    logic [COL_SPACE-1:0] wmask;
    logic                 dropped;
    logic [X_W-1:0]       base;
    logic [COL_SPACE-1:0] rd_shift;

    always_comb begin
        // pixel ops
        px_clip  = ({1'b0, i_cmd.x} >= COL_W'(PANEL_WIDTH));
        py_clip  = ({1'b0, i_cmd.y} >= (Y_W+1)'(PANEL_HEIGHT));
        px       = px_clip ? X_W'(PANEL_WIDTH - 1) : i_cmd.x;
        pix_mask = {1'b1, {(COL_SPACE-1){1'b0}}} >> px;

        // blit length and clipping
        n_sat    = (i_cmd.row_len > LEN_W'(SRC_W)) ? LEN_W'(SRC_W) : i_cmd.row_len;
        cx_lt    = (i_cmd.clip_x < i_cmd.x);
        diff     = i_cmd.clip_x - i_cmd.x;
        if (cx_lt) begin
            n_len    = '0;
            len_clip = (n_sat != '0);
        end else if (LEN_W'(diff) < n_sat) begin
            n_len    = LEN_W'(diff);
            len_clip = 1'b1;
        end else begin
            n_len    = n_sat;
            len_clip = 1'b0;
        end
        row_skip = (i_cmd.y > i_cmd.clip_y) || py_clip;
        span     = (~({COL_SPACE{1'b1}} >> n_len)) >> i_cmd.x;
        src      = {i_cmd.row_bits, {(COL_SPACE-SRC_W){1'b0}}} >> i_cmd.x;
        wmask    = span & PANEL_MASK;
        dropped  = |(span & ~PANEL_MASK);

        // byte read
        base     = {i_cmd.x[X_W-1:3], 3'b000};
        rd_shift = i_old_row << base;

        o_wr.addr      = f_row_addr(i_cmd.mode, i_cmd.y);
        o_wr.en        = 1'b0;
        o_wr.data      = i_old_row;
        o_res.read_byte = '0;
        o_res.clipped   = 1'b0;

        case (i_cmd.mode)
            MODE_SET: begin
                o_wr.en       = 1'b1;
                o_wr.data     = i_old_row | pix_mask;
                o_res.clipped = px_clip | py_clip;
            end
            MODE_CLR: begin
                o_wr.en       = 1'b1;
                o_wr.data     = i_old_row & ~pix_mask;
                o_res.clipped = px_clip | py_clip;
            end
            MODE_BLIT: begin
                o_wr.en       = !row_skip;
                o_wr.data     = (i_old_row & ~wmask) | (src & wmask);
                o_res.clipped = len_clip | (row_skip ? (n_len != '0) : dropped);
            end
            default: begin
                o_res.read_byte = rd_shift[COL_SPACE-1 -: BYTE_W];
                o_res.clipped   = py_clip || ({1'b0, base} >= COL_W'(PANEL_WIDTH));
            end
        endcase
    end

endmodule

// ===== rtl/mono_framebuffer_blitter_core.sv =====
// Top level of the mono framebuffer blitter: stream ports, pipeline and forwarding.
//
// Usage: one command beat on the s_axis side gives exactly one result beat on
// the m_axis side, in order. Commands: set pixel, clear pixel, blit one sprite
// row (up to 64 source bits, clipped by clip_x/clip_y and the panel edge), and
// read one framebuffer byte. Framebuffer is 128x64, one bit per pixel.
// Pipeline: the row is read at accept into the row stage; the row update and
// the result register follow when that stage advances to m_axis_tvalid.
// Throughput: one command per cycle while not stalled; back-to-back writes to
// the same row are forwarded from the last write, so no bubbles are inserted.
// Reset (i_rst_n low, synchronous): pipeline emptied and every row marked
// blank, so the whole framebuffer reads as zero at once; no clearing pass.
// Stall: while m_axis_tready is low the result holds, one more command can
// sit in the row stage, then s_axis_tready drops.
`timescale 1ns / 1ps

module mono_framebuffer_blitter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mode[1:0], x[8:2], y[14:9], row_bits[78:15], row_len[85:79],
    // clip_x[92:86], clip_y[98:93], zero pad [103:99]
    input  logic [mfb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_byte[7:0], clipped[8], zero pad [15:9]
    output logic [mfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mfb_pkg::*;

    t_cmd                 in_cmd;
    t_cmd                 r_s1_cmd;
    logic                 r_s1_valid;
    logic                 s1_adv;
    logic                 in_acc;
    logic [Y_W-1:0]       rd_addr;
    logic [COL_SPACE-1:0] mem_row;
    logic [COL_SPACE-1:0] old_row;
    t_mem_wr              wr;
    t_result              res;
    t_result              r_res;
    logic                 r_out_valid;
    logic                 r_fwd_en;
    logic [Y_W-1:0]       r_fwd_addr;
    logic [COL_SPACE-1:0] r_fwd_row;

    assign in_cmd.mode     = t_mode'(s_axis_tdata[1:0]);
    assign in_cmd.x        = s_axis_tdata[8:2];
    assign in_cmd.y        = s_axis_tdata[14:9];
    assign in_cmd.row_bits = s_axis_tdata[78:15];
    assign in_cmd.row_len  = s_axis_tdata[85:79];
    assign in_cmd.clip_x   = s_axis_tdata[92:86];
    assign in_cmd.clip_y   = s_axis_tdata[98:93];

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rd_addr       = f_row_addr(in_cmd.mode, in_cmd.y);

    mfb_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_row),
        .i_wr      ('{en: wr.en & s1_adv, addr: wr.addr, data: wr.data})
    );

    // last write always holds the newest copy of its row
    assign old_row = (r_fwd_en && (r_fwd_addr == f_row_addr(r_s1_cmd.mode, r_s1_cmd.y)))
                     ? r_fwd_row : mem_row;

    mfb_cmd_unit u_cmd (
        .i_cmd     (r_s1_cmd),
        .i_old_row (old_row),
        .o_wr      (wr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_en    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv && wr.en) begin
                r_fwd_en <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd <= in_cmd;
        end
        if (s1_adv) begin
            r_res <= res;
        end
        if (s1_adv && wr.en) begin
            r_fwd_addr <= wr.addr;
            r_fwd_row  <= wr.data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-BYTE_W-1){1'b0}}, r_res.clipped, r_res.read_byte};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the mono framebuffer blitter core.
`timescale 1ns / 1ps

module testbench;
    import mfb_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // mode[1:0], x[8:2], y[14:9], row_bits[78:15], row_len[85:79],
    // clip_x[92:86], clip_y[98:93], zero pad [103:99]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // read_byte[7:0], clipped[8], zero pad [15:9]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    mono_framebuffer_blitter_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Column c of a row lives in bit COL_SPACE-1-c.
    logic [COL_SPACE-1:0] frame_rows [ROW_DEPTH];
    t_cmd                 pending_cmds [$];
    t_result              expected_results [$];
    t_cmd                 cmd_on_bus;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   err_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Updates the framebuffer copy and returns the result of one command.
    function automatic t_result apply_command(input t_cmd c);
        t_result     r;
        int unsigned n, col, base, px, py, i;
        r = '0;
        case (c.mode)
            MODE_SET, MODE_CLR: begin
                px = c.x;
                py = c.y;
                if (px >= PANEL_WIDTH) begin
                    px = PANEL_WIDTH - 1;
                    r.clipped = 1'b1;
                end
                if (py >= PANEL_HEIGHT) begin
                    py = PANEL_HEIGHT - 1;
                    r.clipped = 1'b1;
                end
                frame_rows[py][COL_SPACE-1-px] = (c.mode == MODE_SET);
            end
            MODE_BLIT: begin
                n = (c.row_len > SRC_W) ? SRC_W : c.row_len;
                if (c.clip_x < c.x) begin
                    if (n != 0) r.clipped = 1'b1;
                    n = 0;
                end else if (int'(c.clip_x) - int'(c.x) < n) begin
                    n = int'(c.clip_x) - int'(c.x);
                    r.clipped = 1'b1;
                end
                if (c.y > c.clip_y || c.y >= PANEL_HEIGHT) begin
                    if (n != 0) r.clipped = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        col = c.x + i;
                        if (col >= PANEL_WIDTH) r.clipped = 1'b1;
                        else frame_rows[c.y][COL_SPACE-1-col] = c.row_bits[SRC_W-1-i];
                    end
                end
            end
            default: begin
                base = (c.x / PIXELS_PER_BYTE) * PIXELS_PER_BYTE;
                for (i = 0; i < BYTE_W; i++)
                    r.read_byte[BYTE_W-1-i] = frame_rows[c.y][COL_SPACE-1-(base+i)];
                if (c.y >= PANEL_HEIGHT || base >= PANEL_WIDTH) r.clipped = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic add_cmd(input t_mode mode, input int x, input int y,
                           input logic [SRC_W-1:0] bits, input int len,
                           input int cx, input int cy);
        t_cmd c;
        c.mode     = mode;
        c.x        = X_W'(x);
        c.y        = Y_W'(y);
        c.row_bits = bits;
        c.row_len  = LEN_W'(len);
        c.clip_x   = X_W'(cx);
        c.clip_y   = Y_W'(cy);
        pending_cmds.push_back(c);
    endtask

    // Rows 0..7 are favored so back-to-back hits on one row are common.
    task automatic add_random_cmds(input int count);
        t_cmd c;
        for (int k = 0; k < count; k++) begin
            c.mode     = t_mode'($urandom_range(3));
            c.x        = X_W'($urandom_range(127));
            c.y        = ($urandom_range(1) != 0) ? Y_W'($urandom_range(7))
                                                  : Y_W'($urandom_range(63));
            c.row_bits = {$urandom, $urandom};
            c.row_len  = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(127))
                                                  : LEN_W'($urandom_range(64));
            c.clip_x   = ($urandom_range(3) == 0) ? X_W'(127) : X_W'($urandom_range(127));
            c.clip_y   = ($urandom_range(3) == 0) ? Y_W'(63) : Y_W'($urandom_range(63));
            if (c.mode == MODE_BLIT && $urandom_range(2) == 0 && c.clip_x < c.x)
                c.clip_x = X_W'(127);
            pending_cmds.push_back(c);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_command(cmd_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, cmd_on_bus.clip_y, cmd_on_bus.clip_x,
                                      cmd_on_bus.row_len, cmd_on_bus.row_bits,
                                      cmd_on_bus.y, cmd_on_bus.x, cmd_on_bus.mode};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, tdata %h",
                                              m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.read_byte)
                        report_mismatch($sformatf("read_byte %h, want %h",
                                                  m_axis_tdata[7:0], want.read_byte));
                    if (m_axis_tdata[8] !== want.clipped)
                        report_mismatch($sformatf("clipped %b, want %b",
                                                  m_axis_tdata[8], want.clipped));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        for (int r = 0; r < ROW_DEPTH; r++) frame_rows[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 58;
        add_cmd(MODE_READ, 0, 0, '1, 127, 127, 63);
        add_cmd(MODE_SET, 0, 0, '0, 0, 0, 0);
        add_cmd(MODE_SET, 127, 63, '1, 64, 0, 0);
        add_cmd(MODE_SET, 7, 0, '0, 0, 0, 0);
        add_cmd(MODE_READ, 3, 0, '0, 0, 0, 0);
        add_cmd(MODE_READ, 127, 63, '0, 0, 0, 0);
        // clear must drop only the addressed pixel
        add_cmd(MODE_CLR, 0, 0, '1, 127, 127, 63);
        add_cmd(MODE_READ, 0, 0, '0, 0, 0, 0);
        add_cmd(MODE_BLIT, 0, 5, '1, 64, 127, 63);
        add_cmd(MODE_READ, 56, 5, '0, 0, 0, 0);
        add_cmd(MODE_READ, 64, 5, '0, 0, 0, 0);
        // blit an alternating pattern across the half boundary clears and sets pixels
        add_cmd(MODE_BLIT, 60, 5, 64'h5555_0000_0000_0000, 16, 127, 63);
        add_cmd(MODE_READ, 60, 5, '0, 0, 0, 0);
        add_cmd(MODE_READ, 64, 5, '0, 0, 0, 0);
        // right clip shortens the run
        add_cmd(MODE_BLIT, 100, 6, '1, 64, 127, 63);
        add_cmd(MODE_READ, 120, 6, '0, 0, 0, 0);
        // clip_x left of x
        add_cmd(MODE_BLIT, 50, 7, '1, 5, 10, 63);
        add_cmd(MODE_BLIT, 50, 7, '1, 0, 10, 63);
        // row below clip_y
        add_cmd(MODE_BLIT, 0, 40, '1, 8, 127, 20);
        add_cmd(MODE_BLIT, 0, 40, '1, 0, 127, 20);
        add_cmd(MODE_READ, 0, 40, '0, 0, 0, 0);
        // oversized length saturates silently
        add_cmd(MODE_BLIT, 0, 63, 64'hF0F0_F0F0_F0F0_F0F0, 127, 127, 63);
        add_cmd(MODE_READ, 8, 63, '0, 0, 0, 0);
        add_cmd(MODE_BLIT, 127, 63, '1, 1, 127, 63);
        add_random_cmds(220);
        wait_drained();

        send_idle_pct = 58;
        recv_idle_pct = 29;
        add_random_cmds(240);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_cmds(240);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== mono_framebuffer_blitter_core.f =====
rtl/mfb_pkg.sv
rtl/mfb_frame_mem.sv
rtl/mfb_cmd_unit.sv
rtl/mono_framebuffer_blitter_core.sv
sim/testbench.sv
